// File: src/mhnt_pkg.sv
package mhnt_pkg;

  localparam int OP_W    = 2;
  localparam int CHAN_W  = 4;
  localparam int NOTE_W  = 7;
  localparam int PVAL_W  = 7;
  localparam int MASK_W  = 12;
  localparam int CLASS_W = 4;
  localparam int COUNT_W = 8;

  localparam logic [PVAL_W-1:0]  PEDAL_THRESHOLD = 7'd64;
  localparam logic [CLASS_W-1:0] PC_LAST         = 4'd11;

  typedef enum logic [OP_W-1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_PEDAL    = 2'd2,
    OP_ALL_OFF  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } st_e;

  typedef struct packed {
    op_e               op;
    logic [CHAN_W-1:0] channel;
    logic [NOTE_W-1:0] note;
    logic              note_ok;
    logic              down;
  } cmd_t;

endpackage

// File: src/mhnt_front.sv
module mhnt_front import mhnt_pkg::*; #(
  parameter int CHANNELS = 16,
  parameter int NOTES    = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [OP_W-1:0]   op_i,
  input  logic [CHAN_W-1:0] channel_i,
  input  logic [NOTE_W-1:0] note_i,
  input  logic [PVAL_W-1:0] pedal_value_i,
  input  logic              busy_i,
  output cmd_t              cmd_o,
  output logic              cmd_valid_o,
  input  logic              cmd_take_i
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       cls;
  logic       push_ok, take_ok;

  always_comb begin
    cls.op      = op_e'(op_i);
    cls.channel = ({1'b0, channel_i} >= (CHAN_W+1)'(CHANNELS)) ?
                  CHAN_W'(CHANNELS - 1) : channel_i;
    cls.note    = note_i;
    cls.note_ok = ({1'b0, note_i} < (NOTE_W+1)'(NOTES));
    cls.down    = (pedal_value_i >= PEDAL_THRESHOLD);
  end

  assign full        = (cnt_q == 2'd2) || busy_i;
  assign push_ok     = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign take_ok     = cmd_take_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (take_ok) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_ok, take_ok})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: src/mhnt_back.sv
module mhnt_back import mhnt_pkg::*; #(
  parameter int CHANNELS = 16,
  parameter int NOTES    = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_take_o,
  output logic               busy_o,
  output logic               empty,
  input  logic               pop,
  output logic [MASK_W-1:0]  pitch_class_mask_o,
  output logic               has_notes_o,
  output logic [CLASS_W-1:0] bass_class_o,
  output logic [COUNT_W-1:0] active_notes_o
);

  localparam int AW = $clog2(NOTES);
  localparam int WW = 2 * CHANNELS;
  localparam logic [AW-1:0] ADDR_LAST = AW'(NOTES - 1);

  logic [WW-1:0] store_q [NOTES];
  logic [WW-1:0] rd_data_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa;
  logic [WW-1:0] mem_wd;

  st_e                state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic               rel_q, rel_d;
  logic               ped_q, ped_d;
  logic [CHANNELS-1:0] pedal_q, pedal_d;
  logic [AW-1:0]      rd_addr_q, rd_addr_d;
  logic [CLASS_W-1:0] cls_q, cls_d;
  logic               issue_q, issue_d;
  logic               s1_v_q, s1_v_d;
  logic [AW-1:0]      s1_addr_q, s1_addr_d;
  logic [CLASS_W-1:0] s1_cls_q, s1_cls_d;
  logic [MASK_W-1:0]  mask_q, mask_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               found_q, found_d;
  logic [CLASS_W-1:0] bass_q, bass_d;
  logic               res_v_q, res_v_d;
  logic [MASK_W-1:0]  res_mask_q, res_mask_d;
  logic               res_has_q, res_has_d;
  logic [CLASS_W-1:0] res_bass_q, res_bass_d;
  logic [COUNT_W-1:0] res_cnt_q, res_cnt_d;

  logic [CHANNELS-1:0] in_bit, row_bit;
  logic [CHANNELS-1:0] held, sust, nh, ns;
  logic                sound;

  assign in_bit  = {{(CHANNELS-1){1'b0}}, 1'b1} << cmd_i.channel;
  assign row_bit = {{(CHANNELS-1){1'b0}}, 1'b1} << cmd_q.channel;
  assign held    = rd_data_q[CHANNELS-1:0];
  assign sust    = rd_data_q[WW-1:CHANNELS];

  always_comb begin
    nh = held;
    ns = sust;
    case (cmd_q.op)
      OP_NOTE_ON: begin
        if (cmd_q.note_ok && (cmd_q.note == NOTE_W'(s1_addr_q))) begin
          nh = held | row_bit;
          ns = sust & ~row_bit;
        end
      end
      OP_NOTE_OFF: begin
        if (cmd_q.note_ok && (cmd_q.note == NOTE_W'(s1_addr_q))) begin
          nh = held & ~row_bit;
          ns = ped_q ? (sust | row_bit) : (sust & ~row_bit);
        end
      end
      OP_PEDAL: begin
        if (rel_q) begin
          ns = sust & ~(row_bit & ~held);
        end
      end
      default: begin
        nh = held & ~row_bit;
        ns = sust & ~row_bit;
      end
    endcase
    sound = |(nh | ns);
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    rel_d      = rel_q;
    ped_d      = ped_q;
    pedal_d    = pedal_q;
    rd_addr_d  = rd_addr_q;
    cls_d      = cls_q;
    issue_d    = issue_q;
    s1_v_d     = 1'b0;
    s1_addr_d  = s1_addr_q;
    s1_cls_d   = s1_cls_q;
    mask_d     = mask_q;
    cnt_d      = cnt_q;
    found_d    = found_q;
    bass_d     = bass_q;
    res_v_d    = res_v_q;
    res_mask_d = res_mask_q;
    res_has_d  = res_has_q;
    res_bass_d = res_bass_q;
    res_cnt_d  = res_cnt_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wa     = s1_addr_q;
    mem_wd     = {ns, nh};
    cmd_take_o = 1'b0;

    if (res_v_q && pop) begin
      res_v_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = rd_addr_q;
        mem_wd = '0;
        if (rd_addr_q == ADDR_LAST) begin
          rd_addr_d = '0;
          state_d   = ST_IDLE;
        end else begin
          rd_addr_d = rd_addr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          cmd_d      = cmd_i;
          ped_d      = |(pedal_q & in_bit);
          rel_d      = (cmd_i.op == OP_PEDAL) && (|(pedal_q & in_bit)) && !cmd_i.down;
          if (cmd_i.op == OP_PEDAL) begin
            pedal_d = cmd_i.down ? (pedal_q | in_bit) : (pedal_q & ~in_bit);
          end else if (cmd_i.op == OP_ALL_OFF) begin
            pedal_d = pedal_q & ~in_bit;
          end
          rd_addr_d = '0;
          cls_d     = '0;
          issue_d   = 1'b1;
          mask_d    = '0;
          cnt_d     = '0;
          found_d   = 1'b0;
          bass_d    = '0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_q) begin
          mem_re    = 1'b1;
          s1_v_d    = 1'b1;
          s1_addr_d = rd_addr_q;
          s1_cls_d  = cls_q;
          cls_d     = (cls_q == PC_LAST) ? '0 : cls_q + CLASS_W'(1);
          if (rd_addr_q == ADDR_LAST) begin
            issue_d = 1'b0;
          end else begin
            rd_addr_d = rd_addr_q + AW'(1);
          end
        end
        if (s1_v_q) begin
          mem_we = 1'b1;
          if (sound) begin
            mask_d = mask_q | (MASK_W'(1) << s1_cls_q);
            cnt_d  = cnt_q + COUNT_W'(1);
            if (!found_q) begin
              found_d = 1'b1;
              bass_d  = s1_cls_q;
            end
          end
          if (s1_addr_q == ADDR_LAST) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!res_v_q || pop) begin
          res_v_d    = 1'b1;
          res_mask_d = mask_q;
          res_has_d  = found_q;
          res_bass_d = bass_q;
          res_cnt_d  = cnt_q;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= store_q[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    rel_q      <= rel_d;
    ped_q      <= ped_d;
    cls_q      <= cls_d;
    s1_addr_q  <= s1_addr_d;
    s1_cls_q   <= s1_cls_d;
    mask_q     <= mask_d;
    cnt_q      <= cnt_d;
    found_q    <= found_d;
    bass_q     <= bass_d;
    res_mask_q <= res_mask_d;
    res_has_q  <= res_has_d;
    res_bass_q <= res_bass_d;
    res_cnt_q  <= res_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      pedal_q   <= '0;
      rd_addr_q <= '0;
      issue_q   <= 1'b0;
      s1_v_q    <= 1'b0;
      res_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      pedal_q   <= pedal_d;
      rd_addr_q <= rd_addr_d;
      issue_q   <= issue_d;
      s1_v_q    <= s1_v_d;
      res_v_q   <= res_v_d;
    end
  end

  assign busy_o             = (state_q == ST_CLEAR);
  assign empty              = !res_v_q;
  assign pitch_class_mask_o = res_mask_q;
  assign has_notes_o        = res_has_q;
  assign bass_class_o       = res_bass_q;
  assign active_notes_o     = res_cnt_q;

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_SCAN))
    else $error("Store written outside the clearing pass or a scan.");

  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (!issue_q && !s1_v_q))
    else $error("Scan pipeline still busy when the result is ready.");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_v_q) |-> ($past(state_q) == ST_DONE))
    else $error("Result appeared without a finished scan.");

  a_summary_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && cnt_q == '0) |-> (mask_q == '0 && !found_q))
    else $error("Summary reports classes with no sounding note.");

endmodule

// File: src/midi_held_note_pitch_class_tracker_unit.sv
// Channel   Direction  Handshake                 Payload
// request   in         push / full               op_i, channel_i, note_i, pedal_value_i
// result    out        empty / pop               pitch_class_mask_o, has_notes_o,
//                                                bass_class_o, active_notes_o
//
// For each request the back end reads, updates and writes one note row of the store
// per cycle and sums the result on the way.
// After reset all NOTES rows of the store are cleared, one row per cycle, with full held high.
// Two requests can wait in the front queue while the back end works.
// A finished result waits in the output register; the back end holds it until it is popped.
module midi_held_note_pitch_class_tracker_unit import mhnt_pkg::*; #(
  parameter int CHANNELS = 16,
  parameter int NOTES    = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [OP_W-1:0]    op_i,
  input  logic [CHAN_W-1:0]  channel_i,
  input  logic [NOTE_W-1:0]  note_i,
  input  logic [PVAL_W-1:0]  pedal_value_i,
  output logic               empty,
  input  logic               pop,
  output logic [MASK_W-1:0]  pitch_class_mask_o,
  output logic               has_notes_o,
  output logic [CLASS_W-1:0] bass_class_o,
  output logic [COUNT_W-1:0] active_notes_o
);

  cmd_t cmd;
  logic cmd_valid, cmd_take, busy;

  mhnt_front #(
    .CHANNELS(CHANNELS),
    .NOTES   (NOTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .channel_i    (channel_i),
    .note_i       (note_i),
    .pedal_value_i(pedal_value_i),
    .busy_i       (busy),
    .cmd_o        (cmd),
    .cmd_valid_o  (cmd_valid),
    .cmd_take_i   (cmd_take)
  );

  mhnt_back #(
    .CHANNELS(CHANNELS),
    .NOTES   (NOTES)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cmd_valid_i       (cmd_valid),
    .cmd_take_o        (cmd_take),
    .busy_o            (busy),
    .empty             (empty),
    .pop               (pop),
    .pitch_class_mask_o(pitch_class_mask_o),
    .has_notes_o       (has_notes_o),
    .bass_class_o      (bass_class_o),
    .active_notes_o    (active_notes_o)
  );

endmodule
